// File: rtl/rgbnir_mosaic_interpolator_assert.svh
// Assertion macros for the mosaic interpolator.
`ifndef RGBNIR_MOSAIC_INTERPOLATOR_ASSERT_SVH
`define RGBNIR_MOSAIC_INTERPOLATOR_ASSERT_SVH
// same-cycle implication
`define RMI_ASSERT_NOW(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("rmi check failed");
// next-cycle implication
`define RMI_ASSERT_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("rmi check failed");
`endif

// File: rtl/rmi_pkg.sv
// Shared constants, types and weight table of the mosaic interpolator.
`timescale 1ns / 1ps
package rmi_pkg;
   localparam int MAX_BLOCK_COLS_DEF = 1024;
   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int QUEUE_DEPTH        = 4;
   localparam int MAX_BLOCK_ROWS     = 4096;
   localparam logic [10:0] COLS_RESET = 11'd640;
   localparam logic [12:0] ROWS_RESET = 13'd480;

   typedef enum logic {CSR_BLOCK_COLS = 1'b0, CSR_BLOCK_ROWS = 1'b1} rmi_csr_type;

   // which neighbor arrangement a result beat uses
   typedef enum logic [1:0] {
      STEP_CORNER = 2'd0,
      STEP_TOP    = 2'd1,
      STEP_LEFT   = 2'd2,
      STEP_MAIN   = 2'd3
   } rmi_step_type;

   typedef struct packed {
      logic fire;
      logic busy;
   } rmi_bstat_type;

   // weight of plane q at position pos (0 up-left, 1 up, 2 left, 3 center)
   function automatic logic [3:0] rmi_weight(input logic [1:0] q, input logic [1:0] pos);
      logic [3:0] w;
      w = 4'd3;
      case (q)
         2'd0: w = (pos == 2'd0) ? 4'd1 : (pos == 2'd3) ? 4'd9 : 4'd3;
         2'd1: w = (pos == 2'd1) ? 4'd1 : (pos == 2'd2) ? 4'd9 : 4'd3;
         2'd2: w = (pos == 2'd2) ? 4'd1 : (pos == 2'd1) ? 4'd9 : 4'd3;
         2'd3: w = (pos == 2'd3) ? 4'd1 : (pos == 2'd0) ? 4'd9 : 4'd3;
         default: w = 4'd3;
      endcase
      return w;
   endfunction
endpackage

// File: rtl/rmi_front.sv
// Front end: raster position, line buffers and block assembly into jobs.
`timescale 1ns / 1ps
module rmi_front #(
   parameter int MAX_BLOCK_COLS = rmi_pkg::MAX_BLOCK_COLS_DEF,
   parameter int SAMPLE_BITS    = rmi_pkg::SAMPLE_BITS_DEF,
   parameter int AW = $clog2(MAX_BLOCK_COLS),
   parameter int JW = 16 * SAMPLE_BITS + 12 + AW + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  rmi_pkg::rmi_csr_type  csr_index,
   input  logic [12:0]           csr_data,
   input  logic                  accept,
   input  logic [15:0]           raw_sample,
   input  logic                  frame_start,
   output logic                  job_push,
   output logic [JW-1:0]         job_data
);
   import rmi_pkg::*;
   localparam int SB = SAMPLE_BITS;
   localparam int CW = $clog2(2 * MAX_BLOCK_COLS) + 1;

   logic [10:0] cols_ff;
   logic [12:0] rows_ff;
   logic [CW-1:0] col_ff, col_cur, col_in;
   logic [12:0] row_ff, row_cur, row_in;
   logic [SB-1:0] held_ff, s;
   logic [4*SB-1:0] left_ff, uleft_ff, prev_rd_ff, c;
   logic [2*SB-1:0] upper_rd_ff;
   logic [2*SB-1:0] upper_mem [MAX_BLOCK_COLS];
   logic [4*SB-1:0] prev_mem  [MAX_BLOCK_COLS];
   logic [31:0] s_wide;
   logic [AW-1:0] j;
   logic [11:0] i;
   logic [CW:0] eff_cols2;
   logic [13:0] eff_rows2;
   logic odd_row, odd_col;

   assign s_wide  = 32'(raw_sample);
   assign s       = s_wide[SB-1:0];
   assign col_cur = frame_start ? '0 : col_ff;
   assign row_cur = frame_start ? '0 : row_ff;
   assign odd_row = row_cur[0];
   assign odd_col = col_cur[0];
   assign i       = row_cur[12:1];
   assign j       = col_cur[AW:1];
   assign c       = {s, held_ff, upper_rd_ff};

   always_comb begin
      if (cols_ff < 11'd2) eff_cols2 = (CW+1)'(4);
      else if (32'(cols_ff) > MAX_BLOCK_COLS) eff_cols2 = (CW+1)'(2 * MAX_BLOCK_COLS);
      else eff_cols2 = (CW+1)'({cols_ff, 1'b0});
      if (rows_ff < 13'd2) eff_rows2 = 14'd4;
      else if (32'(rows_ff) > MAX_BLOCK_ROWS) eff_rows2 = 14'(2 * MAX_BLOCK_ROWS);
      else eff_rows2 = {rows_ff, 1'b0};
   end

   always_comb begin
      col_in = col_cur + 1'b1;
      row_in = row_cur;
      if ((CW+1)'(col_cur) + 1'b1 >= eff_cols2) begin
         col_in = '0;
         if (14'(row_cur) + 1'b1 >= eff_rows2) row_in = '0;
         else row_in = row_cur + 1'b1;
      end
   end

   assign job_push = accept && odd_row && odd_col && (i != '0) && (j != '0);
   assign job_data = {uleft_ff, prev_rd_ff, left_ff, c, i, j, (i == 12'd1), (j == AW'(1))};

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COLS_RESET;
         rows_ff  <= ROWS_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
         held_ff  <= '0;
         left_ff  <= '0;
         uleft_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BLOCK_COLS: cols_ff <= csr_data[10:0];
               CSR_BLOCK_ROWS: rows_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            if (!odd_col) held_ff <= s;
            if (odd_row && odd_col) begin
               left_ff  <= c;
               uleft_ff <= prev_rd_ff;
            end
         end
      end
   end

   // line buffers; fetch this block's upper data while its red sample arrives
   always_ff @(posedge clock) begin
      if (accept && !odd_row && odd_col) upper_mem[j] <= {s, held_ff};
      if (accept && odd_row && odd_col) prev_mem[j] <= c;
      if (accept && odd_row && !odd_col) begin
         upper_rd_ff <= upper_mem[j];
         prev_rd_ff  <= prev_mem[j];
      end
   end
endmodule

// File: rtl/rmi_queue.sv
// Small job queue between front and back ends.
`timescale 1ns / 1ps
module rmi_queue #(
   parameter int W = 8,
   parameter int DEPTH = rmi_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output logic [W-1:0] head
);
   import rmi_pkg::*;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [W-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [NW-1:0] cnt_ff;

   assign full  = (cnt_ff == NW'(DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (32'(wr_ff) == DEPTH - 1) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (32'(rd_ff) == DEPTH - 1) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + NW'(push) - NW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule

// File: rtl/rmi_back.sv
// Back end: expands a job into result beats and forms the weighted sums.
`timescale 1ns / 1ps
module rmi_back #(
   parameter int MAX_BLOCK_COLS = rmi_pkg::MAX_BLOCK_COLS_DEF,
   parameter int SAMPLE_BITS    = rmi_pkg::SAMPLE_BITS_DEF,
   parameter int AW = $clog2(MAX_BLOCK_COLS),
   parameter int JW = 16 * SAMPLE_BITS + 12 + AW + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  logic [JW-1:0]          job_data,
   output logic                   job_pop,
   output rmi_pkg::rmi_bstat_type stat,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [19:0]            rsp_nir_value,
   output logic [19:0]            rsp_blue_value,
   output logic [19:0]            rsp_green_value,
   output logic [19:0]            rsp_red_value,
   output logic [11:0]            rsp_out_row,
   output logic [9:0]             rsp_out_col,
   output logic                   rsp_last_of_burst
);
   import rmi_pkg::*;
   localparam int SB = SAMPLE_BITS;
   localparam int VW = SB + 4;

   logic [4*SB-1:0] ul, u, l, c;
   logic [4*SB-1:0] a [4];
   logic [11:0] i;
   logic [AW-1:0] j;
   logic i1, j1, fire, busy_ff, valid_ff;
   logic [3:0] rem_ff, cur, rem_next;
   rmi_step_type step;
   logic [VW-1:0] v [4];
   logic [19:0] val_ff [4];
   logic [11:0] row_ff;
   logic [9:0] col_ff;
   logic last_ff;
   logic [31:0] j_wide;

   assign {ul, u, l, c, i, j, i1, j1} = job_data;
   assign j_wide = 32'(j);

   assign cur = busy_ff ? rem_ff : {1'b1, j1, i1, i1 & j1};

   always_comb begin
      if (cur[0]) step = STEP_CORNER;
      else if (cur[1]) step = STEP_TOP;
      else if (cur[2]) step = STEP_LEFT;
      else step = STEP_MAIN;
   end

   assign rem_next = cur & (cur - 4'd1);
   assign fire     = job_valid && (!valid_ff || rsp_pop);
   assign job_pop  = fire && (rem_next == '0);
   assign stat     = '{fire: fire, busy: busy_ff};

   // arrange the four blocks into up-left, up, left, center order
   always_comb begin
      case (step)
         STEP_CORNER: begin a[0] = c;  a[1] = l;  a[2] = u; a[3] = ul; end
         STEP_TOP:    begin a[0] = l;  a[1] = c;  a[2] = ul; a[3] = u; end
         STEP_LEFT:   begin a[0] = u;  a[1] = ul; a[2] = c; a[3] = l; end
         default:     begin a[0] = ul; a[1] = u;  a[2] = l; a[3] = c; end
      endcase
   end

   always_comb begin
      for (int q = 0; q < 4; q++) begin
         v[q] = '0;
         for (int p = 0; p < 4; p++) begin
            v[q] = v[q] + VW'(a[p][q*SB +: SB]) * VW'(rmi_weight(2'(q), 2'(p)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         rem_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            busy_ff  <= (rem_next != '0);
            rem_ff   <= rem_next;
            valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // hold the beat until it is popped
   always_ff @(posedge clock) begin
      if (fire) begin
         for (int q = 0; q < 4; q++) val_ff[q] <= 20'(32'(v[q]));
         row_ff  <= (step == STEP_CORNER || step == STEP_TOP) ? '0 : i;
         col_ff  <= (step == STEP_CORNER || step == STEP_LEFT) ? '0 : j_wide[9:0];
         last_ff <= (rem_next == '0);
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_nir_value     = val_ff[0];
   assign rsp_blue_value    = val_ff[1];
   assign rsp_red_value     = val_ff[2];
   assign rsp_green_value   = val_ff[3];
   assign rsp_out_row       = row_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_last_of_burst = last_ff;
endmodule

// File: rtl/rgbnir_mosaic_interpolator.sv
// A result beat is registered in the back end when its job fires; it holds until popped.
// Throughput: one raw sample per cycle while not full; each block past row 0 and column 0 yields one
// to four beats, one per cycle from the back end while popped; a four-entry job queue absorbs bursts.
// Row 0 and column 0 results burst out with block rows/columns 1.
// Reset (synchronous, active high) clears counters, queue and output valid; line
// buffers hold undefined data until written and need no clearing pass.
`timescale 1ns / 1ps
module rgbnir_mosaic_interpolator #(
   parameter int MAX_BLOCK_COLS = rmi_pkg::MAX_BLOCK_COLS_DEF,
   parameter int SAMPLE_BITS    = rmi_pkg::SAMPLE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  rmi_pkg::rmi_csr_type csr_index,
   input  logic [12:0]          csr_data,
   input  logic                 push,
   output logic                 full,
   input  logic [15:0]          req_raw_sample,
   input  logic                 req_frame_start,
   output logic                 empty,
   input  logic                 pop,
   output logic [19:0]          rsp_nir_value,
   output logic [19:0]          rsp_blue_value,
   output logic [19:0]          rsp_green_value,
   output logic [19:0]          rsp_red_value,
   output logic [11:0]          rsp_out_row,
   output logic [9:0]           rsp_out_col,
   output logic                 rsp_last_of_burst
);
   import rmi_pkg::*;
   `include "rgbnir_mosaic_interpolator_assert.svh"
   localparam int AW = $clog2(MAX_BLOCK_COLS);
   localparam int JW = 16 * SAMPLE_BITS + 12 + AW + 2;

   logic accept, q_push, q_full, q_pop, q_valid;
   logic [JW-1:0] q_in, q_head;
   rmi_bstat_type bstat;

   assign csr_ready = 1'b1;
   assign full      = q_full;
   assign accept    = push && !q_full;

   rmi_front #(.MAX_BLOCK_COLS(MAX_BLOCK_COLS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .csr_write(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .accept(accept), .raw_sample(req_raw_sample), .frame_start(req_frame_start),
      .job_push(q_push), .job_data(q_in)
   );

   rmi_queue #(.W(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .valid(q_valid), .head(q_head)
   );

   rmi_back #(.MAX_BLOCK_COLS(MAX_BLOCK_COLS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job_data(q_head), .job_pop(q_pop), .stat(bstat),
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_nir_value(rsp_nir_value), .rsp_blue_value(rsp_blue_value),
      .rsp_green_value(rsp_green_value), .rsp_red_value(rsp_red_value),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_last_of_burst(rsp_last_of_burst)
   );

   `RMI_ASSERT_NOW(a_push_not_full, q_push, !q_full)
   `RMI_ASSERT_NOW(a_pop_on_fire, q_pop, bstat.fire && q_valid)
   `RMI_ASSERT_NEXT(a_fire_shows_beat, bstat.fire, !empty)
   `RMI_ASSERT_NOW(a_busy_has_job, bstat.busy, q_valid)
endmodule
